[hw/rtl/pmst_pkg.sv]
// Package of shared types, field widths and codes for the dense Prim spanning tree engine.
`default_nettype none

package pmst_pkg;

  // Default sizes handed to the top level's parameters.
  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_WEIGHT_BITS  = 16;

  // Field widths of the stream items.
  localparam int OP_W      = 1;
  localparam int VTX_W     = 5;
  localparam int WIN_W     = 16;
  localparam int IDX_W     = 5;
  localparam int COST_W    = 16;
  localparam int TOTAL_W   = 21;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  // Configuration register.
  localparam int VC_W = 6;
  localparam logic [VC_W-1:0] VC_RESET = 6'd32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Input item kinds, carried in tuser.
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_RUN   = 1'b1;

  // Result status codes, carried in tuser.
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DISCONN  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [IDX_W-1:0]   edge_index;
    logic [VTX_W-1:0]   from_vertex;
    logic [VTX_W-1:0]   to_vertex;
    logic [COST_W-1:0]  edge_cost;
    logic [TOTAL_W-1:0] total_cost;
    logic               status;
    logic               last;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } seq_stat_t;

endpackage

`default_nettype wire

[hw/rtl/pmst_wmem.sv]
// Weight matrix memory: one write port and one registered read port.
`default_nettype none

module pmst_wmem #(
  parameter int DEPTH = pmst_pkg::DEF_MAX_VERTICES * pmst_pkg::DEF_MAX_VERTICES,
  parameter int WIDTH = pmst_pkg::DEF_WEIGHT_BITS,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pmst_seq.sv]
// Round sequencer: scans the weight memory, tracks the lightest cut edge and builds results.
`default_nettype none

module pmst_seq #(
  parameter int MAX_VERTICES = pmst_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = pmst_pkg::DEF_WEIGHT_BITS,
  localparam int AW = $clog2(MAX_VERTICES * MAX_VERTICES)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         run_go,
  input  wire logic [pmst_pkg::VC_W-1:0]    vertex_count,
  output logic                              rd_en,
  output logic      [AW-1:0]                rd_addr,
  input  wire logic [WEIGHT_BITS-1:0]       rd_data,
  input  wire logic                         res_ready,
  output pmst_pkg::seq_stat_t               stat,
  output pmst_pkg::res_t                    res
);

  localparam int VIDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int EXT_W  = ((WEIGHT_BITS > pmst_pkg::TOTAL_W) ?
                           WEIGHT_BITS : pmst_pkg::TOTAL_W) + 1;
  localparam logic [WEIGHT_BITS-1:0] NO_EDGE = {WEIGHT_BITS{1'b1}};

  pmst_pkg::seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]                 n_r, n_nxt;
  logic [VIDX_W-1:0]                i_r, i_nxt;
  logic [VIDX_W-1:0]                j_r, j_nxt;
  logic                             rd_v_r, rd_v_nxt;
  logic [VIDX_W-1:0]                rd_i_r, rd_i_nxt;
  logic [VIDX_W-1:0]                rd_j_r, rd_j_nxt;
  logic [WEIGHT_BITS-1:0]           best_r, best_nxt;
  logic [VIDX_W-1:0]                a_r, a_nxt;
  logic [VIDX_W-1:0]                b_r, b_nxt;
  logic                             found_r, found_nxt;
  logic [MAX_VERTICES-1:0]          in_tree_r, in_tree_nxt;
  logic [CNT_W-1:0]                 edges_r, edges_nxt;
  logic [pmst_pkg::TOTAL_W-1:0]     sum_r, sum_nxt;
  pmst_pkg::res_t                   res_r, res_nxt;

  logic [7:0]                       vc_ext;
  logic [CNT_W-1:0]                 n_start;
  logic                             scan_end;
  logic                             cut_pair;
  logic [EXT_W-1:0]                 sum_ext;
  logic [pmst_pkg::TOTAL_W-1:0]     sum_sat;
  logic [EXT_W-1:0]                 best_ext;

  function automatic logic [pmst_pkg::IDX_W-1:0] IDX_CAST(input logic [CNT_W-1:0] v);
    logic [7:0] w;
    w = 8'(v);
    return w[pmst_pkg::IDX_W-1:0];
  endfunction

  function automatic logic [pmst_pkg::VTX_W-1:0] VTX_CAST(input logic [VIDX_W-1:0] v);
    logic [7:0] w;
    w = 8'(v);
    return w[pmst_pkg::VTX_W-1:0];
  endfunction

  // Vertex count of zero runs as one vertex; anything above the matrix size saturates.
  always_comb begin
    vc_ext = 8'(vertex_count);
    if (vc_ext == 8'd0) begin
      n_start = CNT_W'(1);
    end else if (vc_ext > 8'(MAX_VERTICES)) begin
      n_start = CNT_W'(MAX_VERTICES);
    end else begin
      n_start = CNT_W'(vc_ext);
    end
  end

  assign scan_end = (i_r == VIDX_W'(n_r - 1'b1)) && (j_r == VIDX_W'(n_r - 1'b1));
  assign cut_pair = (rd_i_r != rd_j_r) && (in_tree_r[rd_i_r] != in_tree_r[rd_j_r]);
  assign best_ext = EXT_W'(best_r);
  assign sum_ext  = EXT_W'(sum_r) + best_ext;
  assign sum_sat  = (sum_ext > EXT_W'(pmst_pkg::TOTAL_MAX)) ?
                    pmst_pkg::TOTAL_MAX : sum_ext[pmst_pkg::TOTAL_W-1:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pmst_pkg::S_IDLE: begin
        if (run_go) begin
          if (n_start == CNT_W'(1)) begin
            state_nxt = pmst_pkg::S_EMIT;
          end else begin
            state_nxt = pmst_pkg::S_SCAN;
          end
        end
      end
      pmst_pkg::S_SCAN: begin
        if (scan_end) begin
          state_nxt = pmst_pkg::S_DRAIN;
        end
      end
      pmst_pkg::S_DRAIN:  state_nxt = pmst_pkg::S_DECIDE;
      pmst_pkg::S_DECIDE: state_nxt = pmst_pkg::S_EMIT;
      pmst_pkg::S_EMIT: begin
        if (res_ready) begin
          if (res_r.last) begin
            state_nxt = pmst_pkg::S_IDLE;
          end else begin
            state_nxt = pmst_pkg::S_SCAN;
          end
        end
      end
      default: state_nxt = pmst_pkg::S_IDLE;
    endcase
  end

  // Outputs decoded from the state.
  always_comb begin
    stat.idle      = 1'b0;
    stat.res_valid = 1'b0;
    rd_en          = 1'b0;
    case (state_r)
      pmst_pkg::S_IDLE: stat.idle      = 1'b1;
      pmst_pkg::S_SCAN: rd_en          = 1'b1;
      pmst_pkg::S_EMIT: stat.res_valid = 1'b1;
      default: begin
        stat.idle = 1'b0;
      end
    endcase
  end

  assign rd_addr = AW'(i_r) * AW'(MAX_VERTICES) + AW'(j_r);
  assign res     = res_r;

  // Datapath next values.
  always_comb begin
    n_nxt       = n_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    rd_v_nxt    = 1'b0;
    rd_i_nxt    = i_r;
    rd_j_nxt    = j_r;
    best_nxt    = best_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    found_nxt   = found_r;
    in_tree_nxt = in_tree_r;
    edges_nxt   = edges_r;
    sum_nxt     = sum_r;
    res_nxt     = res_r;

    // The entry read in the previous cycle is compared against the best so far.
    if (rd_v_r && cut_pair && (rd_data < best_r)) begin
      best_nxt  = rd_data;
      a_nxt     = rd_i_r;
      b_nxt     = rd_j_r;
      found_nxt = 1'b1;
    end

    case (state_r)
      pmst_pkg::S_IDLE: begin
        if (run_go) begin
          n_nxt          = n_start;
          in_tree_nxt    = '0;
          in_tree_nxt[0] = 1'b1;
          edges_nxt      = '0;
          sum_nxt        = '0;
          i_nxt          = '0;
          j_nxt          = '0;
          best_nxt       = NO_EDGE;
          found_nxt      = 1'b0;
          res_nxt        = '0;
          res_nxt.status = pmst_pkg::STATUS_OK;
          res_nxt.last   = 1'b1;
        end
      end
      pmst_pkg::S_SCAN: begin
        rd_v_nxt = 1'b1;
        if (j_r == VIDX_W'(n_r - 1'b1)) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      pmst_pkg::S_DECIDE: begin
        res_nxt.edge_index = IDX_CAST(edges_r);
        if (found_r) begin
          in_tree_nxt[a_r]    = 1'b1;
          in_tree_nxt[b_r]    = 1'b1;
          edges_nxt           = edges_r + 1'b1;
          sum_nxt             = sum_sat;
          res_nxt.from_vertex = VTX_CAST(a_r);
          res_nxt.to_vertex   = VTX_CAST(b_r);
          res_nxt.edge_cost   = best_ext[pmst_pkg::COST_W-1:0];
          res_nxt.total_cost  = sum_sat;
          res_nxt.status      = pmst_pkg::STATUS_OK;
          res_nxt.last        = (CNT_W'(edges_r + 1'b1) == CNT_W'(n_r - 1'b1));
        end else begin
          res_nxt.from_vertex = '0;
          res_nxt.to_vertex   = '0;
          res_nxt.edge_cost   = '0;
          res_nxt.total_cost  = sum_r;
          res_nxt.status      = pmst_pkg::STATUS_DISCONN;
          res_nxt.last        = 1'b1;
        end
      end
      pmst_pkg::S_EMIT: begin
        if (res_ready && !res_r.last) begin
          i_nxt     = '0;
          j_nxt     = '0;
          best_nxt  = NO_EDGE;
          found_nxt = 1'b0;
        end
      end
      default: begin
        rd_v_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pmst_pkg::S_IDLE;
      rd_v_r    <= 1'b0;
      in_tree_r <= '0;
      edges_r   <= '0;
      sum_r     <= '0;
      found_r   <= 1'b0;
      n_r       <= CNT_W'(1);
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_v_r    <= rd_v_nxt;
      in_tree_r <= in_tree_nxt;
      edges_r   <= edges_nxt;
      sum_r     <= sum_nxt;
      found_r   <= found_nxt;
      n_r       <= n_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_i_r <= rd_i_nxt;
    rd_j_r <= rd_j_nxt;
    best_r <= best_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
  end

  // A read result only arrives in the cycle after a scan cycle issued it.
  a_read_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> ($past(state_r) == pmst_pkg::S_SCAN))
    else $error("memory read data marked valid without a scan cycle before it");

  // A chosen edge crosses the cut, so it adds exactly one vertex to the tree.
  a_tree_grows_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmst_pkg::S_DECIDE && found_r) |=>
      ($countones(in_tree_r) == $countones($past(in_tree_r)) + 1))
    else $error("tree did not grow by exactly one vertex");

  // The root stays in the tree for the whole scan.
  a_root_in_tree: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pmst_pkg::S_SCAN) |-> in_tree_r[0])
    else $error("root vertex missing from the tree during a scan");

  // A run never finds as many edges as it has vertices.
  a_edges_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != pmst_pkg::S_IDLE) |-> (edges_r < n_r))
    else $error("edge count reached the vertex count");

endmodule

`default_nettype wire

[hw/rtl/prim_mst_adjacency_matrix.sv]
// Top level of the dense-matrix Prim spanning tree engine: ports, configuration and output stage.
//
//  channel  direction  transaction             payload
//  in_      slave      weight write or run     tuser op, tdata row/col/weight
//  out_     master     one tree edge result    tuser status, tlast last, tdata edge fields
//  cfg_     slave      vertex_count write      cfg_data
//
// A weight write goes straight into the weight memory; in_tready stays high between runs.
// A run of n vertices takes up to n-1 rounds; every round reads
// the whole n by n corner of the weight memory through its single read port, one entry a cycle.
// in_tready is low from the run transaction until its last result has left the sequencer.
// A stalled out_tready holds the output register; the next round scans behind it.
// Reset is synchronous; the weight memory is not cleared and reads garbage until written.
`default_nettype none

module prim_mst_adjacency_matrix #(
  parameter int MAX_VERTICES = pmst_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = pmst_pkg::DEF_WEIGHT_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // row [4:0], col [9:5], weight [25:10], zero [31:26]
  input  wire logic [pmst_pkg::IN_DATA_W-1:0]    in_tdata,
  // op [0]
  input  wire logic [pmst_pkg::OP_W-1:0]         in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // edge_index [4:0], from_vertex [9:5], to_vertex [14:10], edge_cost [30:15],
  // total_cost [51:31], zero [55:52]
  output logic      [pmst_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status [0]
  output logic                                   out_tuser,
  output logic                                   out_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pmst_pkg::VC_W-1:0]         cfg_data
);

  localparam int DEPTH = MAX_VERTICES * MAX_VERTICES;
  localparam int AW    = $clog2(DEPTH);

  logic [pmst_pkg::VC_W-1:0]  vertex_count_r;
  logic                       out_valid_r;
  pmst_pkg::res_t             out_res_r;

  logic                       in_acc;
  logic [pmst_pkg::VTX_W-1:0] wr_row;
  logic [pmst_pkg::VTX_W-1:0] wr_col;
  logic                       wr_in_range;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [WEIGHT_BITS-1:0]     wr_data;
  logic                       run_go;
  logic                       rd_en;
  logic [AW-1:0]              rd_addr;
  logic [WEIGHT_BITS-1:0]     rd_data;
  logic                       res_ready;
  pmst_pkg::seq_stat_t        stat;
  pmst_pkg::res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= pmst_pkg::VC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count_r <= cfg_data;
    end
  end

  assign in_tready   = stat.idle;
  assign in_acc      = in_tvalid && in_tready;
  assign wr_row      = in_tdata[4:0];
  assign wr_col      = in_tdata[9:5];
  assign wr_in_range = (8'(wr_row) < 8'(MAX_VERTICES)) && (8'(wr_col) < 8'(MAX_VERTICES));
  assign wr_en       = in_acc && (in_tuser == pmst_pkg::OP_WRITE) && wr_in_range;
  assign wr_addr     = AW'(wr_row) * AW'(MAX_VERTICES) + AW'(wr_col);
  assign wr_data     = WEIGHT_BITS'(in_tdata[25:10]);
  assign run_go      = in_acc && (in_tuser == pmst_pkg::OP_RUN);

  pmst_wmem #(
    .DEPTH (DEPTH),
    .WIDTH (WEIGHT_BITS)
  ) u_wmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pmst_seq #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .run_go       (run_go),
    .vertex_count (vertex_count_r),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .res_ready    (res_ready),
    .stat         (stat),
    .res          (res)
  );

  // The output register frees the sequencer as soon as a result is copied out.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.total_cost, out_res_r.edge_cost,
                       out_res_r.to_vertex, out_res_r.from_vertex, out_res_r.edge_index};
  assign out_tuser  = out_res_r.status;
  assign out_tlast  = out_res_r.last;

endmodule

`default_nettype wire
